### rtl/core/wrsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wrsi_pkg;

  // Width of the smoothing period register.
  localparam int WIN_W = 8;

  // Fill status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } wrsi_qstat_t;

endpackage
`default_nettype wire

### rtl/core/wrsi_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wrsi_front #(
  parameter int PRICE_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [PRICE_BITS-1:0]   price,
  input  wire wrsi_pkg::wrsi_qstat_t   qstat,
  output logic                         push,
  output logic [2*PRICE_BITS:0]        push_data
);
  import wrsi_pkg::*;

  logic [PRICE_BITS-1:0] prev;
  logic                  have_prev;
  logic [PRICE_BITS-1:0] gain;
  logic [PRICE_BITS-1:0] loss;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  // Split the change into gain and loss magnitudes.
  always_comb begin
    gain = '0;
    loss = '0;
    if (price > prev) begin
      gain = price - prev;
    end else begin
      loss = prev - price;
    end
  end

  // Entry: {first sample, gain, loss}
  assign push_data = {!have_prev, gain, loss};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      have_prev <= 1'b0;
    end else if (push) begin
      prev      <= price;
      have_prev <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/wrsi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module wrsi_queue #(
  parameter int W = 49
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [W-1:0]          push_data,
  input  wire logic                  pop,
  output logic [W-1:0]               pop_data,
  output wrsi_pkg::wrsi_qstat_t      qstat
);
  import wrsi_pkg::*;

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign pop_data    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/core/wrsi_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wrsi_back #(
  parameter int PRICE_BITS = 24,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_WINDOW = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [wrsi_pkg::WIN_W-1:0]    win,
  input  wire wrsi_pkg::wrsi_qstat_t         qstat,
  input  wire logic [2*PRICE_BITS:0]         pop_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [FRAC_BITS+6:0]               rsi_value,
  output logic                               ready_res
);
  import wrsi_pkg::*;

  localparam int ACC_W = PRICE_BITS + FRAC_BITS;
  localparam int DIV_W = ACC_W + 1;
  localparam int NUM_W = PRICE_BITS + 2 * FRAC_BITS + 8;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int RSI_W = FRAC_BITS + 7;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [2:0] OP_MEAN_G = 3'd0;
  localparam logic [2:0] OP_MEAN_L = 3'd1;
  localparam logic [2:0] OP_SM_G   = 3'd2;
  localparam logic [2:0] OP_SM_L   = 3'd3;
  localparam logic [2:0] OP_RATIO  = 3'd4;

  logic [1:0]            state;
  logic [2:0]            op;
  logic                  primed;
  logic [WIN_W-1:0]      cnt;
  logic [ACC_W-1:0]      acc_g;
  logic [ACC_W-1:0]      acc_l;
  logic [PRICE_BITS-1:0] loss_x;
  logic                  neg;
  logic [RSI_W-1:0]      res_rsi;
  logic                  res_rdy;

  // shared restoring divider
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] dcnt;

  logic [DIV_W:0]        rem_sh;
  logic                  q_bit;
  logic [NUM_W-1:0]      q_nx;
  logic [ACC_W-1:0]      q_acc;
  logic [WIN_W-1:0]      n;
  logic                  e_first;
  logic [PRICE_BITS-1:0] e_gain;
  logic [PRICE_BITS-1:0] e_loss;
  logic [ACC_W-1:0]      sum_g;
  logic [ACC_W-1:0]      sum_l;
  logic [WIN_W-1:0]      cnt_inc;
  logic [ACC_W-1:0]      sm_g_val;
  logic [ACC_W-1:0]      sm_l_val;

  assign {e_first, e_gain, e_loss} = pop_data;
  assign pop = (state == S_IDLE) && !qstat.empty;

  always_comb begin
    if (win < WIN_W'(2)) begin
      n = WIN_W'(2);
    end else if (32'(win) > MAX_WINDOW) begin
      n = WIN_W'(MAX_WINDOW);
    end else begin
      n = win;
    end
  end

  assign rem_sh = {rem, num[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dsr});
  assign q_nx   = {quo[NUM_W-2:0], q_bit};
  assign q_acc  = q_nx[ACC_W-1:0];

  assign sum_g   = acc_g + ACC_W'(e_gain);
  assign sum_l   = acc_l + ACC_W'(e_loss);
  assign cnt_inc = cnt + WIN_W'(1);

  assign sm_g_val = neg ? (acc_g - q_acc) : (acc_g + q_acc);
  assign sm_l_val = neg ? (acc_l - q_acc) : (acc_l + q_acc);

  // Smoothing step numerator: |x - avg|, rounded toward minus infinity when negative.
  function automatic logic [NUM_W:0] sm_num(input logic [PRICE_BITS-1:0] x,
                                            input logic [ACC_W-1:0] a,
                                            input logic [WIN_W-1:0] nn);
    logic [ACC_W-1:0] xf;
    xf = {x, {FRAC_BITS{1'b0}}};
    if (xf >= a) begin
      sm_num = {1'b0, NUM_W'(xf - a)};
    end else begin
      sm_num = {1'b1, NUM_W'(a - xf) + NUM_W'(nn) - NUM_W'(1)};
    end
  endfunction

  // G * 100 * 2^FRAC as shifts and adds
  function automatic logic [NUM_W-1:0] mul100(input logic [ACC_W-1:0] g);
    mul100 = (NUM_W'(g) << (FRAC_BITS + 6)) + (NUM_W'(g) << (FRAC_BITS + 5))
           + (NUM_W'(g) << (FRAC_BITS + 2));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_MEAN_G;
      primed    <= 1'b0;
      cnt       <= '0;
      acc_g     <= '0;
      acc_l     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            if (e_first) begin
              res_rsi <= '0;
              res_rdy <= 1'b0;
              state   <= S_EMIT;
            end else if (!primed) begin
              acc_g <= sum_g;
              acc_l <= sum_l;
              cnt   <= cnt_inc;
              if (cnt_inc >= n) begin
                num   <= NUM_W'({sum_g, {FRAC_BITS{1'b0}}});
                dsr   <= DIV_W'(cnt_inc);
                rem   <= '0;
                dcnt  <= '0;
                op    <= OP_MEAN_G;
                state <= S_DIV;
              end else begin
                res_rsi <= '0;
                res_rdy <= 1'b0;
                state   <= S_EMIT;
              end
            end else begin
              {neg, num} <= sm_num(e_gain, acc_g, n);
              loss_x <= e_loss;
              dsr    <= DIV_W'(n);
              rem    <= '0;
              dcnt   <= '0;
              op     <= OP_SM_G;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo <= q_nx;
          if (dcnt == LAST) begin
            rem  <= '0;
            dcnt <= '0;
            case (op)
              OP_MEAN_G: begin
                acc_g <= q_acc;
                num   <= NUM_W'({acc_l, {FRAC_BITS{1'b0}}});
                dsr   <= DIV_W'(cnt);
                op    <= OP_MEAN_L;
              end
              OP_MEAN_L: begin
                acc_l  <= (q_acc == '0) ? ACC_W'(1) : q_acc;
                primed <= 1'b1;
                state  <= S_MUL;
              end
              OP_SM_G: begin
                acc_g      <= sm_g_val;
                {neg, num} <= sm_num(loss_x, acc_l, n);
                op         <= OP_SM_L;
              end
              OP_SM_L: begin
                acc_l <= (sm_l_val == '0) ? ACC_W'(1) : sm_l_val;
                state <= S_MUL;
              end
              OP_RATIO: begin
                res_rsi <= q_nx[RSI_W-1:0];
                res_rdy <= 1'b1;
                state   <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            rem  <= q_bit ? DIV_W'(rem_sh - {1'b0, dsr}) : DIV_W'(rem_sh);
            num  <= {num[NUM_W-2:0], 1'b0};
            dcnt <= dcnt + CNT_W'(1);
          end
        end
        S_MUL: begin
          num   <= mul100(acc_g);
          dsr   <= DIV_W'(acc_g) + DIV_W'(acc_l);
          rem   <= '0;
          dcnt  <= '0;
          op    <= OP_RATIO;
          state <= S_DIV;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            rsi_value <= res_rsi;
            ready_res <= res_rdy;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/wilder_rsi_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming relative strength index with Wilder smoothing. One price sample in,
// one result out. The first sample yields ready_res = 0; then each change is
// summed until window_length changes are seen, after which gain and loss
// averages are set to their means and ready_res goes high with
// rsi_value = 100 * G / (G + L) in unsigned Q.FRAC_BITS. Later samples smooth
// the averages as avg += (x - avg) / N. The front takes a sample every cycle
// into a two-entry queue while that queue is not full; the back runs one
// bit-serial divider of NUM_W = PRICE_BITS + 2*FRAC_BITS + 8 steps (64 at the
// default widths). A primed sample takes three divisions plus three control
// steps (pop, product setup, output); the priming step that sets the means
// costs the same, while the first sample and an ordinary priming sample need
// only the pop and output steps. Result stalls lengthen each of these. The
// divider sets the rate. window_length is written through window_length_we;
// the user must write it only while the block is idle, which the block does
// not enforce; values below 2 act as 2, values above MAX_WINDOW as MAX_WINDOW.
module wilder_rsi_stream #(
  parameter int PRICE_BITS = 24,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_WINDOW = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [PRICE_BITS-1:0]         price,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [FRAC_BITS+6:0]               rsi_value,
  output logic                               ready_res,
  // configuration
  input  wire logic                          window_length_we,
  input  wire logic [wrsi_pkg::WIN_W-1:0]    window_length
);
  import wrsi_pkg::*;

  localparam int ENT_W = 2 * PRICE_BITS + 1;

  logic [WIN_W-1:0] win;
  wrsi_qstat_t      qstat;
  logic             push;
  logic             pop;
  logic [ENT_W-1:0] push_data;
  logic [ENT_W-1:0] pop_data;

  // period register, reset value 14
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= WIN_W'(14);
    end else if (window_length_we) begin
      win <= window_length;
    end
  end

  // front: previous price, change split into gain/loss
  wrsi_front #(.PRICE_BITS(PRICE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .price     (price),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the per-transfer front from the multi-cycle back
  wrsi_queue #(.W(ENT_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // back: priming sums, smoothing, ratio, output register
  wrsi_back #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .qstat     (qstat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rsi_value (rsi_value),
    .ready_res (ready_res)
  );

  // not-ready results carry zero
  a_notready_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ready_res |-> rsi_value == '0)
    else $error("not-ready result with nonzero value");

  // RSI never exceeds 100
  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ready_res |-> rsi_value <= ((FRAC_BITS + 7)'(100) << FRAC_BITS))
    else $error("RSI above 100");

  // queue is never popped empty nor pushed full
  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty) && !(push && qstat.full))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire

### tb/tb_wilder_rsi_stream.sv
`timescale 1ns / 1ps

// Expected RSI results, oldest first.
class rsi_scoreboard;
  logic [22:0] rsi_q[$];
  logic        rdy_q[$];
  int          errors;
  int          checked;

  function void note_sample(logic [22:0] rsi, logic rdy);
    rsi_q.push_back(rsi);
    rdy_q.push_back(rdy);
  endfunction

  function void check_result(logic [22:0] rsi, logic rdy);
    logic [22:0] e_rsi;
    logic        e_rdy;
    if (rsi_q.size() == 0) begin
      $display("%0t: unexpected result rsi=%0d ready=%0b", $time, rsi, rdy);
      errors++;
      return;
    end
    e_rsi = rsi_q.pop_front();
    e_rdy = rdy_q.pop_front();
    checked++;
    if (rdy !== e_rdy) begin
      $display("%0t: ready_res expected %0b actual %0b", $time, e_rdy, rdy);
      errors++;
    end
    if (rsi !== e_rsi) begin
      $display("%0t: rsi_value expected %0d actual %0d", $time, e_rsi, rsi);
      errors++;
    end
  endfunction

  function int pending();
    return rsi_q.size();
  endfunction
endclass

module tb_wilder_rsi_stream;
  import wrsi_pkg::*;

  localparam int  FRAC   = 16;
  localparam int  MAXWIN = 255;
  localparam longint HUNDRED = 64'd100 << FRAC;
  localparam longint LIMIT = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] price = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [22:0] rsi_value;
  logic        ready_res;
  logic        window_length_we = 1'b0;
  logic [WIN_W-1:0] window_length = '0;

  always #5 clk = ~clk;

  wilder_rsi_stream i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .price(price),
    .out_valid(out_valid), .out_stall(out_stall),
    .rsi_value(rsi_value), .ready_res(ready_res),
    .window_length_we(window_length_we), .window_length(window_length)
  );

  rsi_scoreboard sb = new();

  // Predictor state, mirrors the block.
  logic [7:0]  win_reg;
  logic [23:0] last_price;
  logic [7:0]  n_changes;
  logic [63:0] gain_avg, loss_avg;
  logic        is_primed, seen_first;

  int     n_sent;
  longint cycles;
  int     stall_mode;

  function automatic longint gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic longint mean_q(longint unsigned s, longint unsigned d);
    longint unsigned q, r;
    q = s / d;
    r = s % d;
    return (q << FRAC) + ((r << FRAC) / d);
  endfunction

  function automatic longint wilder(longint unsigned a, longint unsigned x,
                                    longint unsigned n);
    if (x >= a) return a + (x - a) / n;
    return a - ((a - x) + n - 1) / n;
  endfunction

  // Predict one transfer; averages stay below 2^40, so the product fits 64 bits.
  function automatic void predict(logic [23:0] p);
    longint unsigned n, g, l;
    logic [63:0] d;
    n = (win_reg < 2) ? 2 : (win_reg > MAXWIN ? MAXWIN : win_reg);
    g = 0;
    l = 0;
    if (!seen_first) begin
      seen_first = 1'b1;
      last_price = p;
      sb.note_sample('0, 1'b0);
      return;
    end
    if (p > last_price) g = p - last_price;
    else l = last_price - p;
    last_price = p;
    if (!is_primed) begin
      gain_avg += g;
      loss_avg += l;
      n_changes = n_changes + 8'd1;
      if (n_changes < n) begin
        sb.note_sample('0, 1'b0);
        return;
      end
      gain_avg = mean_q(gain_avg, n_changes);
      loss_avg = mean_q(loss_avg, n_changes);
      is_primed = 1'b1;
    end else begin
      gain_avg = wilder(gain_avg, g << FRAC, n);
      loss_avg = wilder(loss_avg, l << FRAC, n);
    end
    if (loss_avg < 1) loss_avg = 1;
    d = gain_avg + loss_avg;
    sb.note_sample(23'((gain_avg * HUNDRED) / d), 1'b1);
  endfunction

  // Result side: sample at the rising edge, new stall at the falling edge.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(rsi_value, ready_res);

  always @(negedge clk) begin
    if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 19) != 0);
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one sample; valid is held until the transfer happens.
  task automatic send_price(logic [23:0] p);
    longint g;
    g = gap_len();
    @(negedge clk);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    price <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(p);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // Idle-only register write; history and priming state carry over.
  task automatic set_window(logic [7:0] w);
    drain();
    @(negedge clk);
    window_length_we <= 1'b1;
    window_length <= w;
    @(negedge clk);
    window_length_we <= 1'b0;
    win_reg = w;
  endtask

  // Mostly a random walk so RSI stays mid-range, with jumps and flat runs.
  function automatic logic [23:0] next_price(logic [23:0] p);
    int r, step;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      step = $urandom_range(0, 2000) - 1000;
      return 24'(int'(p) + step);
    end
    if (r < 80) return p;
    if (r < 85) return 24'hFFFFFF;
    if (r < 90) return 24'h0;
    return 24'($urandom());
  endfunction

  logic [23:0] walk;
  int          k, phase;
  logic [7:0]  w;

  initial begin
    win_reg = 8'd14;
    last_price = '0;
    n_changes = '0;
    gain_avg = '0;
    loss_avg = '0;
    is_primed = 1'b0;
    seen_first = 1'b0;
    stall_mode = 0;
    cycles = 0;
    n_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, flat input, big swings. The window drops below the
    // change count while priming, so the means divide by the count.
    send_price(24'd0);
    send_price(24'hFFFFFF);
    send_price(24'd0);
    for (k = 0; k < 8; k++) send_price(24'd0);
    set_window(8'd3);
    for (k = 0; k < 6; k++) send_price(24'd0);
    send_price(24'hFFFFFF);
    send_price(24'h000001);
    send_price(24'h555555);
    send_price(24'hAAAAAA);
    send_price(24'hAAAAAA);

    // Window values zero and one act as two.
    set_window(8'd0);
    for (k = 0; k < 6; k++) send_price(24'(k * 37));
    set_window(8'd1);
    send_price(24'd10);
    send_price(24'd5);
    stall_mode = 1;

    // Random phases with windows covering 2, 255 and values in between.
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: w = 8'd2;
        1: w = 8'd255;
        2: w = 8'd3;
        default: w = 8'($urandom_range(0, 255));
      endcase
      set_window(w);
      stall_mode = int'($urandom_range(0, 2));
      walk = 24'($urandom());
      for (k = 0; k < 160; k++) begin
        walk = next_price(walk);
        send_price(walk);
        if (k == 80 && phase == 4) drain();   // sender waits for all results
      end
    end

    drain();
    $display("Sent %0d price samples, checked %0d results over 15 window settings,",
             n_sent, sb.checked);
    $display("including min/max windows, flat input and receiver back-pressure.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
